/* rtl/bfra_pkg.sv */
`default_nettype none
package bfra_pkg;
	localparam int MEM_WORDS = 65536;
	localparam int FREE_ENTRIES = 32;
	localparam int OWNED_ENTRIES = 32;
	localparam int FIDX_W = $clog2(FREE_ENTRIES);
	localparam int OIDX_W = $clog2(OWNED_ENTRIES);
	localparam int BASE_W = 16;
	localparam int SIZE_W = 17;
	localparam int PID_W = 16;

	localparam logic FUNC_ALLOC = 1'b0;
	localparam logic FUNC_RELEASE = 1'b1;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_NO_FIT = 2'd1,
		ST_NO_PID = 2'd2,
		ST_FULL = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_OSCAN,
		S_FSCAN,
		S_APPLY,
		S_MERGE,
		S_DONE
	} state_t;
endpackage
`default_nettype wire

/* rtl/best_fit_region_allocator_core.sv */
// Best-fit region allocator. The block owns one region of MEM_WORDS words and
// keeps a free table (base, size) and an owned table (pid, base, size), each
// in a one-port synchronous memory with registered read data; valid bits
// live in flip-flops. An allocate request (func 0) takes the smallest free
// block that fits, lowest index on ties, carves the request from its bottom
// and records the owner under request_pid or the internal pid counter. A
// release request (func 1) frees the lowest owned entry with request_pid and
// merges the block with the free neighbors below and above, or places it in
// the lowest empty free entry. Status reports no fit, unknown pid or a full
// table. After reset the block writes the whole region into free entry zero
// in its init state and stalls its input meanwhile. One request is worked at
// a time: the owned table is scanned one entry a cycle, then the free table
// likewise, then an apply state writes the tables and the result. A done
// state, plus a merge state when a release joins both neighbors, follows
// before the block is idle again. The result sits in an output register;
// the next request is taken only once the result has left.
`default_nettype none
module best_fit_region_allocator_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        func,
	input  wire logic [16:0] req_size,
	input  wire logic        use_given_pid,
	input  wire logic [15:0] request_pid,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       status,
	output logic [15:0]      granted_base,
	output logic [15:0]      granted_pid
);
	localparam int FW = bfra_pkg::FIDX_W;
	localparam int OW = bfra_pkg::OIDX_W;
	localparam int BW = bfra_pkg::BASE_W;
	localparam int SW = bfra_pkg::SIZE_W;
	localparam int PW = bfra_pkg::PID_W;

	// Free table memory: base and size packed in one word.
	logic [BW+SW-1:0] fmem [bfra_pkg::FREE_ENTRIES];
	logic [BW+SW-1:0] frd_q;
	logic [FW-1:0]    faddr;
	logic             fwe;
	logic [BW+SW-1:0] fwd;
	logic [bfra_pkg::FREE_ENTRIES-1:0] fvalid_q;

	// Owned table memory: pid, base and size.
	logic [PW+BW+SW-1:0] omem [bfra_pkg::OWNED_ENTRIES];
	logic [PW+BW+SW-1:0] ord_q;
	logic [OW-1:0]       oaddr;
	logic                owe;
	logic [PW+BW+SW-1:0] owd;
	logic [bfra_pkg::OWNED_ENTRIES-1:0] ovalid_q;

	always_ff @(posedge clk) begin
		if (fwe) begin
			fmem[faddr] <= fwd;
		end
		frd_q <= fmem[faddr];
	end

	always_ff @(posedge clk) begin
		if (owe) begin
			omem[oaddr] <= owd;
		end
		ord_q <= omem[oaddr];
	end

	bfra_pkg::state_t state_q, state_d;

	// Request registers.
	logic          func_q, given_q;
	logic [SW-1:0] req_q;
	logic [PW-1:0] rpid_q, next_pid_q;

	// Scan counters: issue index and the index whose data arrives now.
	logic [OW:0] ocnt_q;
	logic [FW:0] fcnt_q;
	logic [OW-1:0] ordi_q;
	logic [FW-1:0] frdi_q;
	logic          ordv_q, frdv_q;

	// Scan results.
	logic          slot_f_q, own_f_q;
	logic [OW-1:0] slot_q, own_q;
	logic [BW-1:0] obase_q;
	logic [SW-1:0] osize_q;
	logic          best_f_q, lo_f_q, hi_f_q, emp_f_q;
	logic [FW-1:0] best_q, lo_q, hi_q, emp_q;
	logic [BW-1:0] bbase_q;
	logic [SW-1:0] bsize_q, losize_q, hisize_q;
	// The low neighbor's base must be kept: in the apply step frd_q holds
	// whatever entry was read last, so the base is latched during the scan.
	logic [BW-1:0] lobase_q;

	logic          ov_q;
	logic [1:0]    st_q;
	logic [BW-1:0] gb_q;
	logic [PW-1:0] gp_q;

	assign in_stall = (state_q != bfra_pkg::S_IDLE) || ov_q;
	assign out_valid = ov_q;
	assign status = st_q;
	assign granted_base = gb_q;
	assign granted_pid = gp_q;

	wire accept = in_valid && !in_stall;
	wire ofin = (state_q == bfra_pkg::S_OSCAN) && !ordv_q &&
		(ocnt_q == (OW+1)'(bfra_pkg::OWNED_ENTRIES));
	wire ffin = (state_q == bfra_pkg::S_FSCAN) && !frdv_q &&
		(fcnt_q == (FW+1)'(bfra_pkg::FREE_ENTRIES));

	// Unpack arriving read data.
	wire [BW-1:0] f_base = frd_q[BW+SW-1:SW];
	wire [SW-1:0] f_size = frd_q[SW-1:0];
	wire [PW-1:0] o_pid  = ord_q[PW+BW+SW-1:BW+SW];
	wire [BW-1:0] o_base = ord_q[BW+SW-1:SW];
	wire [SW-1:0] o_size = ord_q[SW-1:0];
	wire [SW-1:0] bound  = SW'(obase_q) + osize_q;
	wire [SW-1:0] f_end  = SW'(f_base) + f_size;
	wire [SW-1:0] rem    = bsize_q - req_q;

	// Decisions for the apply step.
	logic apply_fail;
	logic [1:0] apply_st;
	always_comb begin
		apply_fail = 1'b0;
		apply_st = bfra_pkg::ST_OK;
		if (func_q == bfra_pkg::FUNC_ALLOC) begin
			if (!slot_f_q) begin
				apply_fail = 1'b1;
				apply_st = bfra_pkg::ST_FULL;
			end else if (!best_f_q || req_q == '0) begin
				apply_fail = 1'b1;
				apply_st = bfra_pkg::ST_NO_FIT;
			end
		end else begin
			if (!own_f_q) begin
				apply_fail = 1'b1;
				apply_st = bfra_pkg::ST_NO_PID;
			end else if (!lo_f_q && !hi_f_q && !emp_f_q) begin
				apply_fail = 1'b1;
				apply_st = bfra_pkg::ST_FULL;
			end
		end
	end

	// Memory port drive and next state.
	always_comb begin
		state_d = state_q;
		faddr = fcnt_q[FW-1:0];
		fwe = 1'b0;
		fwd = '0;
		oaddr = ocnt_q[OW-1:0];
		owe = 1'b0;
		owd = '0;
		unique case (state_q)
			bfra_pkg::S_INIT: begin
				// The whole region starts out as one free block in entry zero.
				faddr = '0;
				fwe = 1'b1;
				fwd = {BW'(0), SW'(bfra_pkg::MEM_WORDS)};
				state_d = bfra_pkg::S_IDLE;
			end
			bfra_pkg::S_IDLE: begin
				if (accept) state_d = bfra_pkg::S_OSCAN;
			end
			bfra_pkg::S_OSCAN: begin
				if (ofin) state_d = bfra_pkg::S_FSCAN;
			end
			bfra_pkg::S_FSCAN: begin
				if (ffin) state_d = bfra_pkg::S_APPLY;
			end
			bfra_pkg::S_APPLY: begin
				state_d = bfra_pkg::S_DONE;
				if (!apply_fail) begin
					if (func_q == bfra_pkg::FUNC_ALLOC) begin
						oaddr = slot_q;
						owe = 1'b1;
						owd = {(given_q ? rpid_q : next_pid_q), bbase_q, req_q};
						faddr = best_q;
						fwe = 1'b1;
						fwd = (rem == '0) ? '0 : {BW'(SW'(bbase_q) + req_q), rem};
					end else if (lo_f_q) begin
						faddr = lo_q;
						fwe = 1'b1;
						fwd = {lobase_q, SW'(losize_q + osize_q +
							(hi_f_q ? hisize_q : SW'(0)))};
						if (hi_f_q) state_d = bfra_pkg::S_MERGE;
					end else if (hi_f_q) begin
						faddr = hi_q;
						fwe = 1'b1;
						fwd = {obase_q, SW'(hisize_q + osize_q)};
					end else begin
						faddr = emp_q;
						fwe = 1'b1;
						fwd = {obase_q, osize_q};
					end
				end
			end
			bfra_pkg::S_MERGE: begin
				faddr = hi_q;
				fwe = 1'b1;
				fwd = '0;
				state_d = bfra_pkg::S_DONE;
			end
			bfra_pkg::S_DONE: begin
				state_d = bfra_pkg::S_IDLE;
			end
			default: state_d = bfra_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bfra_pkg::S_INIT;
			fvalid_q <= {{(bfra_pkg::FREE_ENTRIES-1){1'b0}}, 1'b1};
			ovalid_q <= '0;
			next_pid_q <= PW'(1);
			ov_q <= 1'b0;
			st_q <= '0;
			gb_q <= '0;
			gp_q <= '0;
			ocnt_q <= '0;
			fcnt_q <= '0;
			ordi_q <= '0;
			frdi_q <= '0;
			ordv_q <= 1'b0;
			frdv_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ov_q && !out_stall) ov_q <= 1'b0;
			unique case (state_q)
				bfra_pkg::S_INIT: begin
				end
				bfra_pkg::S_IDLE: begin
					ocnt_q <= '0;
					fcnt_q <= '0;
					ordv_q <= 1'b0;
					frdv_q <= 1'b0;
				end
				bfra_pkg::S_OSCAN: begin
					ordv_q <= (ocnt_q != (OW+1)'(bfra_pkg::OWNED_ENTRIES));
					ordi_q <= ocnt_q[OW-1:0];
					if (ocnt_q != (OW+1)'(bfra_pkg::OWNED_ENTRIES))
						ocnt_q <= ocnt_q + 1'b1;
				end
				bfra_pkg::S_FSCAN: begin
					frdv_q <= (fcnt_q != (FW+1)'(bfra_pkg::FREE_ENTRIES));
					frdi_q <= fcnt_q[FW-1:0];
					if (fcnt_q != (FW+1)'(bfra_pkg::FREE_ENTRIES))
						fcnt_q <= fcnt_q + 1'b1;
				end
				bfra_pkg::S_APPLY: begin
					ov_q <= 1'b1;
					st_q <= apply_st;
					gb_q <= '0;
					gp_q <= '0;
					if (!apply_fail) begin
						if (func_q == bfra_pkg::FUNC_ALLOC) begin
							ovalid_q[slot_q] <= 1'b1;
							if (rem == '0) fvalid_q[best_q] <= 1'b0;
							gb_q <= bbase_q;
							gp_q <= given_q ? rpid_q : next_pid_q;
							if (!given_q) next_pid_q <= next_pid_q + 1'b1;
						end else begin
							ovalid_q[own_q] <= 1'b0;
							gp_q <= rpid_q;
							if (!lo_f_q && !hi_f_q) fvalid_q[emp_q] <= 1'b1;
						end
					end
				end
				bfra_pkg::S_MERGE: begin
					fvalid_q[hi_q] <= 1'b0;
				end
				bfra_pkg::S_DONE: begin
				end
				default: begin
				end
			endcase
		end
	end

	// Scan datapath (payload, no reset).
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= func;
			req_q <= req_size;
			given_q <= use_given_pid;
			rpid_q <= request_pid;
			slot_f_q <= 1'b0;
			own_f_q <= 1'b0;
			best_f_q <= 1'b0;
			lo_f_q <= 1'b0;
			hi_f_q <= 1'b0;
			emp_f_q <= 1'b0;
		end
		if (state_q == bfra_pkg::S_OSCAN && ordv_q) begin
			if (!ovalid_q[ordi_q] && !slot_f_q) begin
				slot_f_q <= 1'b1;
				slot_q <= ordi_q;
			end
			if (ovalid_q[ordi_q] && o_pid == rpid_q && !own_f_q) begin
				own_f_q <= 1'b1;
				own_q <= ordi_q;
				obase_q <= o_base;
				osize_q <= o_size;
			end
		end
		if (state_q == bfra_pkg::S_FSCAN && frdv_q) begin
			if (!fvalid_q[frdi_q]) begin
				if (!emp_f_q) begin
					emp_f_q <= 1'b1;
					emp_q <= frdi_q;
				end
			end else begin
				if (f_size >= req_q && (!best_f_q || f_size < bsize_q)) begin
					best_f_q <= 1'b1;
					best_q <= frdi_q;
					bbase_q <= f_base;
					bsize_q <= f_size;
				end
				if (own_f_q && !lo_f_q && f_end == SW'(obase_q)) begin
					lo_f_q <= 1'b1;
					lo_q <= frdi_q;
					lobase_q <= f_base;
					losize_q <= f_size;
				end
				if (own_f_q && !hi_f_q && SW'(f_base) == bound) begin
					hi_f_q <= 1'b1;
					hi_q <= frdi_q;
					hisize_q <= f_size;
				end
			end
		end
	end
endmodule
`default_nettype wire

/* rtl/bfra_checker.sv */
`default_nettype none
module bfra_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [1:0]  status,
	input wire logic [15:0] granted_base,
	input wire logic [15:0] granted_pid
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) &&
		$stable(granted_base) && $stable(granted_pid))
		else $error("result changed while stalled");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second request taken while busy");
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != bfra_pkg::ST_OK |->
		granted_base == '0 && granted_pid == '0)
		else $error("failure with nonzero payload");
	a_stall_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("request taken while result pending");
endmodule

bind best_fit_region_allocator_core bfra_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .status(status),
	.granted_base(granted_base), .granted_pid(granted_pid)
);
`default_nettype wire
